// ----- rtl/tdlc_pkg.sv -----
package tdlc_pkg;

    localparam logic [7:0] SHORT_PRESS_MAX    = 8'd50;
    localparam logic [7:0] RAMP_INTERVAL      = 8'd10;
    localparam logic [7:0] RESET_LEVEL        = 8'd16;
    localparam logic [7:0] RESET_RAMP_TOP     = 8'd78;
    localparam logic [7:0] RESET_PAUSE_LENGTH = 8'd100;

    localparam logic CFG_RAMP_TOP     = 1'b0;
    localparam logic CFG_PAUSE_LENGTH = 1'b1;

    localparam logic FUNC_HOST_WRITE = 1'b0;
    localparam logic FUNC_CROSSING   = 1'b1;

    typedef struct packed {
        logic [7:0] level;
        logic       ramp_down;
        logic [7:0] press_count;
        logic [7:0] pause_count;
        logic [7:0] saved_level;
    } dim_state_t;

    typedef struct packed {
        logic [7:0] ramp_top;
        logic [7:0] pause_length;
    } dim_cfg_t;

    typedef struct packed {
        logic [7:0] compare_level;
        logic       fire;
        logic [7:0] level_after;
    } dim_result_t;

    // remainder by the ramp interval: reciprocal multiply, exact for 8-bit values
    function automatic logic [7:0] interval_rem(input logic [7:0] x);
        logic [15:0] prod;
        logic [4:0]  quot;
        logic [7:0]  back;
        prod = {8'd0, x} * 16'd205;
        quot = prod[15:11];
        back = 8'({3'd0, quot} * RAMP_INTERVAL);
        return x - back;
    endfunction

endpackage

// ----- rtl/tdlc_update.sv -----
module tdlc_update import tdlc_pkg::*; (
    input  dim_state_t  state,
    input  dim_cfg_t    cfg,
    input  logic        func,
    input  logic [7:0]  new_level,
    input  logic        button_pressed,
    output dim_state_t  state_next,
    output dim_result_t result
);

    logic       ramp_step;
    logic [7:0] stepped_level;
    logic [7:0] press_inc;
    logic       short_press;

    assign press_inc     = state.press_count + 8'd1;
    assign ramp_step     = (state.press_count > SHORT_PRESS_MAX)
                        && (interval_rem(state.press_count) == 8'd0)
                        && (state.pause_count == 8'd0);
    assign stepped_level = state.ramp_down ? state.level - 8'd1 : state.level + 8'd1;
    assign short_press   = (state.press_count != 8'd0)
                        && (state.press_count <= SHORT_PRESS_MAX);

    always_comb begin
        state_next = state;
        if (func == FUNC_HOST_WRITE) begin
            state_next.level = new_level;
        end else if (button_pressed) begin
            state_next.press_count = press_inc;
            if (ramp_step) begin
                state_next.level = stepped_level;
                if (stepped_level == 8'd0) begin
                    state_next.ramp_down = !state.ramp_down;
                end else if (stepped_level == cfg.ramp_top) begin
                    state_next.ramp_down   = !state.ramp_down;
                    state_next.pause_count = cfg.pause_length;
                end
            end else if (state.pause_count != 8'd0) begin
                state_next.pause_count = state.pause_count - 8'd1;
            end
        end else begin
            state_next.press_count = 8'd0;
            if (short_press) begin
                state_next.pause_count = 8'd0;
                if (state.level == 8'd0) begin
                    state_next.level = state.saved_level;
                end else begin
                    state_next.saved_level = state.level;
                    state_next.level       = 8'd0;
                end
            end
        end
    end

    assign result.compare_level = state.level;
    assign result.fire          = (state.level != 8'd0);
    assign result.level_after   = state_next.level;

endmodule

// ----- rtl/touch_dimmer_level_control.sv -----
// One-button phase dimmer level controller.
// Input channel (s_valid/s_ready): one word per event. s_func low is a host
// write that replaces the level and gives no result word. s_func high is a
// mains zero crossing: it yields one result word with the level in force for
// this half-cycle (m_compare_level), m_fire when that level is nonzero, and
// the level after the button rule (m_level_after).
// Config port: cfg_we with cfg_index 0 writes ramp_top, 1 writes pause_length.
// Write only while no word is in flight.
// Latency: a crossing accepted at one edge shows its result word in the next
// cycle. Throughput: one word per cycle unless a stalled receiver holds the
// word; the state update is one pass of logic between the state registers.
// Result register: a stalled receiver holds m_valid and the word; s_ready
// stays high while the result register is empty or being taken this cycle.
// Reset (aresetn low, synchronous): level 16, ramp up, counters and saved
// level 0, ramp_top 78, pause_length 100, no result pending.
module touch_dimmer_level_control import tdlc_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic [7:0] cfg_wdata,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_func,
    input  logic [7:0] s_new_level,
    input  logic       s_button_pressed,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_compare_level,
    output logic       m_fire,
    output logic [7:0] m_level_after
);

    dim_state_t  state_reg;
    dim_state_t  state_next;
    dim_cfg_t    cfg_reg;
    dim_result_t result;
    dim_result_t result_reg;
    logic        m_valid_reg;
    logic        accept;

    tdlc_update u_update (
        .state          (state_reg),
        .cfg            (cfg_reg),
        .func           (s_func),
        .new_level      (s_new_level),
        .button_pressed (s_button_pressed),
        .state_next     (state_next),
        .result         (result)
    );

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.level       <= RESET_LEVEL;
            state_reg.ramp_down   <= 1'b0;
            state_reg.press_count <= 8'd0;
            state_reg.pause_count <= 8'd0;
            state_reg.saved_level <= 8'd0;
        end else if (accept) begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.ramp_top     <= RESET_RAMP_TOP;
            cfg_reg.pause_length <= RESET_PAUSE_LENGTH;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_RAMP_TOP:     cfg_reg.ramp_top     <= cfg_wdata;
                CFG_PAUSE_LENGTH: cfg_reg.pause_length <= cfg_wdata;
                default:          cfg_reg              <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept && s_func == FUNC_CROSSING) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // load the result word on each accepted crossing
    always_ff @(posedge aclk) begin
        if (accept && s_func == FUNC_CROSSING) begin
            result_reg <= result;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_compare_level = result_reg.compare_level;
    assign m_fire          = result_reg.fire;
    assign m_level_after   = result_reg.level_after;

`ifndef SYNTHESIS
    a_fire_matches: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_fire == (m_compare_level != 8'd0)))
        else $error("fire flag does not match compare level");

    a_crossing_gives_word: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_func) |=> m_valid)
        else $error("accepted crossing produced no result word");

    a_host_write_no_word: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && !s_func && m_ready) |=> !m_valid)
        else $error("host write produced a result word");

    a_level_carried: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_func) |=> (m_level_after == state_reg.level))
        else $error("result level differs from stored level");
`endif

endmodule
